@@ rtl/core/dnsap_pkg.sv @@
`timescale 1ns / 1ps

package dnsap_pkg;

    // One byte of the response packet.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in;

    // One parse result.
    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] address;
    } t_out;

    // Outcome of the current byte, handed from the parser to the output stage.
    typedef struct packed {
        logic fire;
        t_out result;
    } t_verdict;

    typedef enum logic [5:0] {
        PH_HEADER = 6'b000001,
        PH_QNAME  = 6'b000010,
        PH_QTAIL  = 6'b000100,
        PH_ANAME  = 6'b001000,
        PH_AFIXED = 6'b010000,
        PH_ADATA  = 6'b100000
    } t_phase;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FORMAT   = 2'd1;
    localparam logic [1:0] ST_NXDOMAIN = 2'd2;
    localparam logic [1:0] ST_SERVFAIL = 2'd3;

    localparam logic [3:0]  HDR_LEN        = 4'd12;
    localparam logic [3:0]  QTAIL_LEN      = 4'd4;
    localparam logic [3:0]  FIXED_LEN      = 4'd10;
    localparam logic [15:0] A_DATA_LEN     = 16'd4;
    localparam logic [15:0] TYPE_A         = 16'd1;
    localparam logic [7:0]  PTR_MASK       = 8'hC0;
    localparam logic [15:0] QR_MASK        = 16'h8000;
    localparam logic [15:0] RCODE_MASK     = 16'h000F;
    localparam logic [15:0] RCODE_NAME_ERR = 16'h0003;

endpackage

@@ rtl/core/dns_response_a_record_parser.sv @@
`timescale 1ns / 1ps

// Streaming DNS response parser: takes one packet byte per cycle and gives
// exactly one result per packet (status plus the first A-record IPv4
// address), as soon as the outcome is decided or at the last byte. Every
// byte is handled in the cycle it is accepted, so a new byte can be taken
// on every clock; the result sits in an output register, and input stall
// rises only while that register holds a result the consumer is stalling.
// The expected transaction id is written through the configuration
// channel, which is always ready and must only be used between packets.
module dns_response_a_record_parser (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  dnsap_pkg::t_in  i_data,
    output logic            o_valid,
    input  logic            i_stall,
    output dnsap_pkg::t_out o_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [15:0]     i_cfg_data
);
    import dnsap_pkg::*;

    logic [15:0] r_expected_id;
    logic        r_out_valid;
    t_out        r_out_data;
    t_verdict    verdict;
    logic        accept;

    assign o_stall     = r_out_valid & i_stall;
    assign accept      = i_valid & ~o_stall;
    assign o_cfg_ready = 1'b1;

    dnsap_parser u_parser (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (accept),
        .i_data        (i_data),
        .i_expected_id (r_expected_id),
        .o_verdict     (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_id <= 16'd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_expected_id <= i_cfg_data;
        end
    end

    // A request is only taken when the output register is empty or draining,
    // so loading it here never drops a pending result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= verdict.fire;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && verdict.fire) begin
            r_out_data <= verdict.result;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

@@ rtl/core/dnsap_parser.sv @@
`timescale 1ns / 1ps

module dnsap_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  dnsap_pkg::t_in     i_data,
    input  logic [15:0]        i_expected_id,
    output dnsap_pkg::t_verdict o_verdict
);
    import dnsap_pkg::*;

    t_phase      r_phase,        n_phase;
    logic [3:0]  r_field_count,  n_field_count;
    logic [15:0] r_header_flags, n_header_flags;
    logic [15:0] r_questions_left, n_questions_left;
    logic [15:0] r_answers_left, n_answers_left;
    logic [15:0] r_skip_left,    n_skip_left;
    logic [15:0] r_record_type,  n_record_type;
    logic [15:0] r_data_length,  n_data_length;
    logic [31:0] r_address_acc,  n_address_acc;
    logic        r_decided,      n_decided;
    logic [15:0] r_received_id,  n_received_id;

    logic        name_end;
    logic [3:0]  name_fc;
    logic [15:0] name_skip;
    logic [15:0] ans_dec;
    logic [15:0] skip_dec;
    logic [15:0] q_dec;
    logic [3:0]  fc_inc;
    logic        is_a;
    logic        fire;
    logic [1:0]  status;
    logic [31:0] address;

    assign ans_dec  = r_answers_left - 16'd1;
    assign skip_dec = r_skip_left - 16'd1;
    assign q_dec    = r_questions_left - 16'd1;
    assign fc_inc   = r_field_count + 4'd1;
    assign is_a     = (r_record_type == TYPE_A) && (r_data_length == A_DATA_LEN);

    // Name walker shared by question and answer names. A pending pointer
    // second byte always ends the name; otherwise label bytes are skipped.
    always_comb begin
        name_end  = 1'b0;
        name_fc   = r_field_count;
        name_skip = r_skip_left;
        if (r_field_count == 4'd1) begin
            name_fc  = 4'd0;
            name_end = 1'b1;
        end else if (r_skip_left != 16'd0) begin
            name_skip = skip_dec;
        end else if (i_data.data_byte == 8'd0) begin
            name_end = 1'b1;
        end else if ((i_data.data_byte & PTR_MASK) == PTR_MASK) begin
            name_fc = 4'd1;
        end else begin
            name_skip = {8'd0, i_data.data_byte};
        end
    end

    always_comb begin
        n_phase          = r_phase;
        n_field_count    = r_field_count;
        n_header_flags   = r_header_flags;
        n_questions_left = r_questions_left;
        n_answers_left   = r_answers_left;
        n_skip_left      = r_skip_left;
        n_record_type    = r_record_type;
        n_data_length    = r_data_length;
        n_address_acc    = r_address_acc;
        n_decided        = r_decided;
        n_received_id    = r_received_id;
        fire             = 1'b0;
        status           = ST_FORMAT;
        address          = 32'd0;

        if (!r_decided) begin
            unique case (r_phase)
                PH_HEADER: begin
                    case (r_field_count) inside
                        4'd0, 4'd1: n_received_id = {r_received_id[7:0], i_data.data_byte};
                        4'd2, 4'd3: n_header_flags = {r_header_flags[7:0], i_data.data_byte};
                        4'd4, 4'd5:
                            n_questions_left = {r_questions_left[7:0], i_data.data_byte};
                        4'd6, 4'd7: n_answers_left = {r_answers_left[7:0], i_data.data_byte};
                        default: ;
                    endcase
                    n_field_count = fc_inc;
                    // The last header byte carries none of the checked fields,
                    // so the stored values are already complete here.
                    if (fc_inc >= HDR_LEN) begin
                        n_field_count = 4'd0;
                        if ((r_received_id != i_expected_id) ||
                            ((r_header_flags & QR_MASK) == 16'd0)) begin
                            fire   = 1'b1;
                            status = ST_FORMAT;
                        end else if ((r_header_flags & RCODE_MASK) == RCODE_NAME_ERR) begin
                            fire   = 1'b1;
                            status = ST_NXDOMAIN;
                        end else if ((r_header_flags & RCODE_MASK) != 16'd0) begin
                            fire   = 1'b1;
                            status = ST_SERVFAIL;
                        end else if (r_answers_left == 16'd0) begin
                            fire   = 1'b1;
                            status = ST_NXDOMAIN;
                        end else begin
                            n_phase     = (r_questions_left == 16'd0) ? PH_ANAME : PH_QNAME;
                            n_skip_left = 16'd0;
                        end
                    end
                end
                PH_QNAME: begin
                    n_field_count = name_fc;
                    n_skip_left   = name_skip;
                    if (name_end) begin
                        n_phase       = PH_QTAIL;
                        n_field_count = 4'd0;
                    end
                end
                PH_QTAIL: begin
                    n_field_count = fc_inc;
                    if (fc_inc >= QTAIL_LEN) begin
                        n_field_count    = 4'd0;
                        n_skip_left      = 16'd0;
                        n_questions_left = q_dec;
                        n_phase          = (q_dec == 16'd0) ? PH_ANAME : PH_QNAME;
                    end
                end
                PH_ANAME: begin
                    n_field_count = name_fc;
                    n_skip_left   = name_skip;
                    if (name_end) begin
                        n_phase       = PH_AFIXED;
                        n_field_count = 4'd0;
                    end
                end
                PH_AFIXED: begin
                    case (r_field_count) inside
                        4'd0, 4'd1: n_record_type = {r_record_type[7:0], i_data.data_byte};
                        4'd8, 4'd9: n_data_length = {r_data_length[7:0], i_data.data_byte};
                        default: ;
                    endcase
                    n_field_count = fc_inc;
                    if (fc_inc >= FIXED_LEN) begin
                        n_field_count = 4'd0;
                        n_address_acc = 32'd0;
                        if (n_data_length == 16'd0) begin
                            n_answers_left = ans_dec;
                            if (ans_dec == 16'd0) begin
                                fire   = 1'b1;
                                status = ST_NXDOMAIN;
                            end else begin
                                n_phase     = PH_ANAME;
                                n_skip_left = 16'd0;
                            end
                        end else begin
                            n_phase     = PH_ADATA;
                            n_skip_left = n_data_length;
                        end
                    end
                end
                PH_ADATA: begin
                    if (is_a) begin
                        n_address_acc = {r_address_acc[23:0], i_data.data_byte};
                    end
                    n_skip_left = skip_dec;
                    if (skip_dec == 16'd0) begin
                        if (is_a) begin
                            fire    = 1'b1;
                            status  = ST_OK;
                            address = n_address_acc;
                        end else begin
                            n_answers_left = ans_dec;
                            if (ans_dec == 16'd0) begin
                                fire   = 1'b1;
                                status = ST_NXDOMAIN;
                            end else begin
                                n_phase       = PH_ANAME;
                                n_field_count = 4'd0;
                                n_skip_left   = 16'd0;
                            end
                        end
                    end
                end
                default: begin
                    fire   = 1'b1;
                    status = ST_FORMAT;
                end
            endcase

            // A packet that ends before an outcome is malformed.
            if (!fire && i_data.last_byte) begin
                fire   = 1'b1;
                status = ST_FORMAT;
            end
            if (fire) begin
                n_decided = 1'b1;
            end
        end

        if (i_data.last_byte) begin
            n_phase          = PH_HEADER;
            n_field_count    = 4'd0;
            n_header_flags   = 16'd0;
            n_questions_left = 16'd0;
            n_answers_left   = 16'd0;
            n_skip_left      = 16'd0;
            n_record_type    = 16'd0;
            n_data_length    = 16'd0;
            n_address_acc    = 32'd0;
            n_decided        = 1'b0;
            n_received_id    = 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_HEADER;
            r_field_count    <= 4'd0;
            r_header_flags   <= 16'd0;
            r_questions_left <= 16'd0;
            r_answers_left   <= 16'd0;
            r_skip_left      <= 16'd0;
            r_record_type    <= 16'd0;
            r_data_length    <= 16'd0;
            r_address_acc    <= 32'd0;
            r_decided        <= 1'b0;
            r_received_id    <= 16'd0;
        end else if (i_accept) begin
            r_phase          <= n_phase;
            r_field_count    <= n_field_count;
            r_header_flags   <= n_header_flags;
            r_questions_left <= n_questions_left;
            r_answers_left   <= n_answers_left;
            r_skip_left      <= n_skip_left;
            r_record_type    <= n_record_type;
            r_data_length    <= n_data_length;
            r_address_acc    <= n_address_acc;
            r_decided        <= n_decided;
            r_received_id    <= n_received_id;
        end
    end

    assign o_verdict.fire           = fire;
    assign o_verdict.result.status  = status;
    assign o_verdict.result.address = (status == ST_OK) ? address : 32'd0;

endmodule
